// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is high
`define TTDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define TTDC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ttdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttdc_pkg
// Types, codes and constants of the touch tap/drag classifier.
// ----------------------------------------------------------------------------
package ttdc_pkg;

   localparam int FRAC_BITS   = 4;
   localparam int COORD_BITS  = 16;
   localparam int PX_BITS     = 12;
   localparam int STEP_BITS   = 14;
   localparam int SLOP_BITS   = 12;
   localparam int WINDOW_BITS = 16;
   localparam int STAMP_BITS  = 32;
   localparam int HALF        = (1 << FRAC_BITS) >> 1;

   localparam logic [SLOP_BITS-1:0]   SLOP_RESET   = 12'd384;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd400;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = 2;
   localparam int CNT_BITS   = 3;

   // register map
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOP   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW = 1'b1;

   typedef enum logic [1:0] {
      CMD_DOWN   = 2'd0,
      CMD_MOVE   = 2'd1,
      CMD_UP     = 2'd2,
      CMD_CANCEL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_HOVER    = 3'd0,
      KIND_WHEEL    = 3'd1,
      KIND_DRAG_END = 3'd2,
      KIND_CLICK    = 3'd3,
      KIND_DOUBLE   = 3'd4
   } kind_type;

   typedef struct packed {
      cmd_type                 command;
      logic [COORD_BITS-1:0]   pos_x;
      logic [COORD_BITS-1:0]   pos_y;
      logic [STAMP_BITS-1:0]   stamp_ms;
   } item_type;

   typedef struct packed {
      kind_type                     kind;
      logic [PX_BITS-1:0]           px_x;
      logic [PX_BITS-1:0]           px_y;
      logic signed [STEP_BITS-1:0]  wheel_step;
      logic signed [STEP_BITS-1:0]  drag_dx;
      logic signed [STEP_BITS-1:0]  drag_dy;
      logic                         last;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;   // 0, 1 or 2 results
      result_type  first;
      result_type  second;
   } push_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  start_x;
      logic [COORD_BITS-1:0]  start_y;
      logic [COORD_BITS-1:0]  prev_y;
      logic                   is_down;
      logic                   is_dragging;
      logic [COORD_BITS-1:0]  tap_x;
      logic [COORD_BITS-1:0]  tap_y;
      logic [STAMP_BITS-1:0]  tap_time;
      logic                   tap_valid;
   } gstate_type;

endpackage

// ===== hw/rtl/ttdc_eval.sv =====
// ----------------------------------------------------------------------------
// ttdc_eval
// One-pass gesture evaluation: next gesture state and the results of one word.
// ----------------------------------------------------------------------------
module ttdc_eval import ttdc_pkg::*; (
   input  item_type                  item,
   input  gstate_type                cur,
   input  logic [SLOP_BITS-1:0]      slop,
   input  logic [WINDOW_BITS-1:0]    window,
   input  logic [2*SLOP_BITS-1:0]    slop_sq,
   output gstate_type                nxt,
   output push_type                  push
);

   function automatic logic [COORD_BITS-1:0] mag_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   logic [COORD_BITS-1:0]     ax, ay, wy, tx, ty, dxm, dym;
   logic [2*COORD_BITS-1:0]   sq_x, sq_y;
   logic [2*COORD_BITS:0]     dist_sq;
   logic                      far;
   logic [COORD_BITS:0]       wy_sum;
   logic [STEP_BITS-2:0]      wy_rnd;
   logic signed [STEP_BITS-1:0] step, dx, dy;
   logic [PX_BITS-1:0]        dx_t, dy_t, px_x, px_y;
   logic [STAMP_BITS-1:0]     elapsed;
   logic                      dbl;
   result_type                base;

   always_comb begin
      ax      = mag_diff(item.pos_x, cur.start_x);
      ay      = mag_diff(item.pos_y, cur.start_y);
      sq_x    = ax * ax;
      sq_y    = ay * ay;
      dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
      far     = dist_sq > (2*COORD_BITS+1)'(slop_sq);

      // wheel step, rounded half away from zero
      wy     = mag_diff(item.pos_y, cur.prev_y);
      wy_sum = {1'b0, wy} + (COORD_BITS+1)'(HALF);
      wy_rnd = wy_sum[FRAC_BITS +: STEP_BITS-1];
      step   = (item.pos_y < cur.prev_y) ? -{1'b0, wy_rnd} : {1'b0, wy_rnd};

      // whole-stroke displacement, toward zero
      dxm  = mag_diff(item.pos_x, cur.start_x);
      dym  = mag_diff(item.pos_y, cur.start_y);
      dx_t = dxm[FRAC_BITS +: PX_BITS];
      dy_t = dym[FRAC_BITS +: PX_BITS];
      dx   = (item.pos_x < cur.start_x) ? -{2'b00, dx_t} : {2'b00, dx_t};
      dy   = (item.pos_y < cur.start_y) ? -{2'b00, dy_t} : {2'b00, dy_t};

      tx      = mag_diff(item.pos_x, cur.tap_x);
      ty      = mag_diff(item.pos_y, cur.tap_y);
      elapsed = item.stamp_ms - cur.tap_time;
      dbl     = cur.tap_valid
                && (elapsed < STAMP_BITS'(window))
                && (tx < COORD_BITS'(slop))
                && (ty < COORD_BITS'(slop));
   end

   always_comb begin
      px_x = item.pos_x[FRAC_BITS +: PX_BITS];
      px_y = item.pos_y[FRAC_BITS +: PX_BITS];

      base.kind        = KIND_HOVER;
      base.px_x        = px_x;
      base.px_y        = px_y;
      base.wheel_step  = '0;
      base.drag_dx     = '0;
      base.drag_dy     = '0;
      base.last        = 1'b1;

      nxt         = cur;
      push.count  = 2'd0;
      push.first  = base;
      push.second = base;

      case (item.command)
         CMD_DOWN: begin
            nxt.start_x     = item.pos_x;
            nxt.start_y     = item.pos_y;
            nxt.prev_y      = item.pos_y;
            nxt.is_dragging = 1'b0;
            nxt.is_down     = 1'b1;
            push.count      = 2'd1;
         end
         CMD_MOVE: begin
            if (cur.is_down && (cur.is_dragging || far)) begin
               nxt.is_dragging        = 1'b1;
               nxt.prev_y             = item.pos_y;
               push.first.kind        = KIND_WHEEL;
               push.first.wheel_step  = step;
               push.count             = (step != '0) ? 2'd1 : 2'd0;
            end
         end
         CMD_UP, CMD_CANCEL: begin
            nxt.is_down     = 1'b0;
            nxt.is_dragging = 1'b0;
            if (item.command == CMD_UP && cur.is_down) begin
               if (cur.is_dragging) begin
                  push.first.kind    = KIND_DRAG_END;
                  push.first.drag_dx = dx;
                  push.first.drag_dy = dy;
                  push.count         = 2'd1;
               end else begin
                  nxt.tap_time     = item.stamp_ms;
                  nxt.tap_x        = item.pos_x;
                  nxt.tap_y        = item.pos_y;
                  nxt.tap_valid    = !dbl;
                  push.first.last  = 1'b0;
                  push.second.kind = dbl ? KIND_DOUBLE : KIND_CLICK;
                  push.count       = 2'd2;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ttdc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ttdc_out_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module ttdc_out_fifo import ttdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        room,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_data
);

   result_type              entry_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // space for a two-result word, judged on the registered count only
   assign room      = (cnt_ff <= CNT_BITS'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      cnt_in    = cnt_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

// ===== hw/rtl/touch_tap_drag_classifier.sv =====
// ----------------------------------------------------------------------------
// touch_tap_drag_classifier
// Single-finger touch classifier: hover, wheel, drag end, click, double click.
// ----------------------------------------------------------------------------
// A new touch word can be taken every cycle while the queue has room. It is
// held in an input register, evaluated combinationally against the gesture
// state, and its zero, one or two results go into a four-entry result queue
// that drives the rsp side. The input register moves on while the queue holds
// two results or fewer, so the sustained rate is one word per cycle as long as
// words produce at most one result each and the rsp side takes them; a tap
// release yields two results, which leave the queue one at a time. Register
// writes take effect for the next word.
module touch_tap_drag_classifier import ttdc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input words
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,  // pos_x[15:0], pos_y[31:16], stamp_ms[63:32]
   input  logic [1:0]                 req_tuser,  // command[1:0]
   // result words
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [71:0]                rsp_tdata,  // px_x[11:0], px_y[23:12],
                                                  // wheel_step[37:24], drag_dx[51:38],
                                                  // drag_dy[65:52], zero pad[71:66]
   output logic [2:0]                 rsp_tuser,  // kind[2:0]
   output logic                       rsp_tlast,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [15:0]                csr_data
);

   logic                      valid_ff, valid_in;
   item_type                  item_ff;
   gstate_type                state_ff, state_nxt;
   logic [SLOP_BITS-1:0]      slop_ff, slop_in;
   logic [WINDOW_BITS-1:0]    window_ff, window_in;
   logic [2*SLOP_BITS-1:0]    slop_sq_ff, slop_sq_in;
   push_type                  push_eval, push_q;
   logic                      room, advance, take;
   result_type                out_data;

   assign advance    = valid_ff && room;
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);
   assign csr_ready  = 1'b1;

   always_comb begin
      slop_in   = slop_ff;
      window_in = window_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SLOP:   slop_in   = csr_data[SLOP_BITS-1:0];
            REG_WINDOW: window_in = csr_data;
            default:    slop_in   = slop_ff;
         endcase
      end
      // square kept in step with the slop register
      slop_sq_in = slop_in * slop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         state_ff   <= '0;
         slop_ff    <= SLOP_RESET;
         window_ff  <= WINDOW_RESET;
         slop_sq_ff <= (2*SLOP_BITS)'(SLOP_RESET * SLOP_RESET);
      end else begin
         valid_ff   <= valid_in;
         slop_ff    <= slop_in;
         window_ff  <= window_in;
         slop_sq_ff <= slop_sq_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.command  <= cmd_type'(req_tuser);
         item_ff.pos_x    <= req_tdata[15:0];
         item_ff.pos_y    <= req_tdata[31:16];
         item_ff.stamp_ms <= req_tdata[63:32];
      end
   end

   ttdc_eval u_eval (
      .item    (item_ff),
      .cur     (state_ff),
      .slop    (slop_ff),
      .window  (window_ff),
      .slop_sq (slop_sq_ff),
      .nxt     (state_nxt),
      .push    (push_eval)
   );

   always_comb begin
      push_q = push_eval;
      if (!advance) begin
         push_q.count = 2'd0;
      end
   end

   ttdc_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_q),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {6'b0, out_data.drag_dy, out_data.drag_dx, out_data.wheel_step,
                       out_data.px_y, out_data.px_x};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

endmodule

// ===== hw/rtl/ttdc_checker.sv =====
// ----------------------------------------------------------------------------
// ttdc_checker
// Port-level checks of the touch classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttdc_checker import ttdc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         rsp_tlast
);

   logic         stalled, nonlast, is_hover, is_click, wheel_zero;
   logic [75:0]  rsp_word;

   assign stalled    = rsp_tvalid && !rsp_tready;
   assign rsp_word   = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign nonlast    = rsp_tvalid && !rsp_tlast;
   assign is_hover   = (rsp_tuser == KIND_HOVER);
   assign is_click   = (rsp_tuser == KIND_CLICK) || (rsp_tuser == KIND_DOUBLE);
   assign wheel_zero = (rsp_tuser == KIND_WHEEL) && (rsp_tdata[37:24] == '0);

   // queue is empty right after reset
   `TTDC_ASSERT_NR(a_empty_after_reset, clock, reset |=> !rsp_tvalid, "result after reset")

   // a held result word keeps its content
   `TTDC_ASSERT(a_hold, clock, reset, stalled |=> rsp_tvalid && $stable(rsp_word), "word changed")

   // only the hover ahead of a click is not last
   `TTDC_ASSERT(a_nonlast_hover, clock, reset, nonlast |-> is_hover, "non-last not hover")

   // a click always closes its word group
   `TTDC_ASSERT(a_click_last, clock, reset, rsp_tvalid && is_click |-> rsp_tlast, "click not last")

   // zero wheel steps never go out
   `TTDC_ASSERT(a_wheel_nonzero, clock, reset, !(rsp_tvalid && wheel_zero), "zero wheel step")

endmodule

bind touch_tap_drag_classifier ttdc_checker u_ttdc_checker (.*);

// ===== verif/tb_touch_tap_drag_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_tap_drag_classifier
// Self-checking bench for the touch tap/drag classifier.
// A short directed table walks the hover, click, double click, wheel and drag
// end paths and their boundaries. Random touch strokes and noise then run
// under several slop and window settings. A gesture predictor follows every
// accepted word and each result word is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_touch_tap_drag_classifier;
   import ttdc_pkg::*;

   localparam int DIR_ROWS    = 28;
   localparam int STALL_LIMIT = 4000;
   localparam int SEGMENTS    = 6;

   typedef struct {
      cmd_type      cmd;
      logic [15:0]  x;
      logic [15:0]  y;
      logic [31:0]  t;
      bit           typed;   // expected words given in the row
      int           n;
      kind_type     k0;
      kind_type     k1;
   } touch_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [63:0]                req_tdata = '0;
   logic [1:0]                 req_tuser = CMD_DOWN;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [71:0]                rsp_tdata;
   logic [2:0]                 rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = REG_SLOP;
   logic [15:0]                csr_data = '0;

   always #5 clock = ~clock;

   touch_tap_drag_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // gesture predictor state and settings
   logic [SLOP_BITS-1:0]    cfg_slop;
   logic [WINDOW_BITS-1:0]  cfg_window;
   logic [15:0]             g_start_x, g_start_y, g_prev_y, g_tap_x, g_tap_y;
   logic [31:0]             g_tap_time;
   bit                      g_down, g_drag, g_tap_ok;

   result_type      step_res[$];
   result_type      pending_gestures[$];
   touch_row_type   stim_q[$];
   touch_row_type   cur_word;

   int           words_issued = 0;
   int           words_taken = 0;
   int           results_seen = 0;
   int           errors = 0;
   int           cfg_writes = 0;
   int           kind_seen[5] = '{0, 0, 0, 0, 0};
   int           send_gap = 13;
   int           recv_gap = 58;
   int           stall_cycles = 0;
   logic [31:0]  now_ms = 32'd5000;
   logic [15:0]  tap_hint_x = 16'd0, tap_hint_y = 16'd0;

   // directed strokes; typed rows carry hover/click/double outcomes,
   // wheel and drag end rows go through the predictor
   touch_row_type dir_tab [DIR_ROWS] = '{
      // move, up and cancel with no finger down
      '{CMD_MOVE,   16'd1000,  16'd1000,  32'd0,        1'b1, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd1000,  16'd1000,  32'd1,        1'b1, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_CANCEL, 16'd1000,  16'd1000,  32'd2,        1'b1, 0, KIND_HOVER, KIND_HOVER},
      // plain tap, then a quick close tap becomes a double
      '{CMD_DOWN,   16'd0,     16'd0,     32'd10,       1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd0,     16'd0,     32'd20,       1'b1, 2, KIND_HOVER, KIND_CLICK},
      '{CMD_DOWN,   16'd100,   16'd100,   32'd50,       1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd100,   16'd100,   32'd60,       1'b1, 2, KIND_HOVER, KIND_DOUBLE},
      // top corner; move exactly at slop stays a tap; no chaining after double
      '{CMD_DOWN,   16'hFFFF,  16'hFFFF,  32'd100,      1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_MOVE,   16'd65151, 16'hFFFF,  32'd105,      1'b1, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'hFFFF,  16'hFFFF,  32'd110,      1'b1, 2, KIND_HOVER, KIND_CLICK},
      // elapsed equal to window and offset equal to slop: plain click
      '{CMD_DOWN,   16'hFFFF,  16'hFFFF,  32'd400,      1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd65151, 16'hFFFF,  32'd510,      1'b1, 2, KIND_HOVER, KIND_CLICK},
      // double tap across the timestamp wrap
      '{CMD_DOWN,   16'd0,     16'd0,     32'hFFFF_FFF0, 1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd0,     16'd0,     32'hFFFF_FFFF, 1'b1, 2, KIND_HOVER, KIND_CLICK},
      '{CMD_DOWN,   16'd5,     16'd5,     32'd0,        1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd5,     16'd5,     32'd16,       1'b1, 2, KIND_HOVER, KIND_DOUBLE},
      // drag: wheel steps incl. half-pixel rounding both ways, then drag end
      '{CMD_DOWN,   16'd1000,  16'd1000,  32'd1000,     1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_MOVE,   16'd1000,  16'd1400,  32'd1010,     1'b0, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_MOVE,   16'd1000,  16'd1408,  32'd1020,     1'b0, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_MOVE,   16'd1000,  16'd1400,  32'd1030,     1'b0, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_MOVE,   16'd0,     16'd0,     32'd1040,     1'b0, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd0,     16'hFFFF,  32'd1050,     1'b0, 0, KIND_HOVER, KIND_HOVER},
      // second down restarts the stroke
      '{CMD_DOWN,   16'd3000,  16'd3000,  32'd2000,     1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_DOWN,   16'd3100,  16'd3000,  32'd2010,     1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd3100,  16'd3000,  32'd2020,     1'b1, 2, KIND_HOVER, KIND_CLICK},
      // cancel drops the touch, the following up is ignored
      '{CMD_DOWN,   16'd500,   16'd500,   32'd3000,     1'b1, 1, KIND_HOVER, KIND_HOVER},
      '{CMD_CANCEL, 16'd500,   16'd500,   32'd3010,     1'b1, 0, KIND_HOVER, KIND_HOVER},
      '{CMD_UP,     16'd500,   16'd500,   32'd3020,     1'b1, 0, KIND_HOVER, KIND_HOVER}
   };

   function automatic int px_half_away(input int d);
      int m;
      m = (d < 0) ? -d : d;
      m = (m + HALF) >>> FRAC_BITS;
      return (d < 0) ? -m : m;
   endfunction

   function automatic int px_toward_zero(input int d);
      int m;
      m = (d < 0) ? -d : d;
      m = m >>> FRAC_BITS;
      return (d < 0) ? -m : m;
   endfunction

   function automatic int abs_diff(input logic [15:0] a, input logic [15:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic result_type mk_result(input kind_type k, input logic [15:0] x,
                                            input logic [15:0] y, input int wheel,
                                            input int dx, input int dy, input bit last);
      result_type r;
      r.kind        = k;
      r.px_x        = PX_BITS'(x >> FRAC_BITS);
      r.px_y        = PX_BITS'(y >> FRAC_BITS);
      r.wheel_step  = STEP_BITS'(wheel);
      r.drag_dx     = STEP_BITS'(dx);
      r.drag_dy     = STEP_BITS'(dy);
      r.last        = last;
      return r;
   endfunction

   function automatic void reset_gestures();
      cfg_slop   = SLOP_RESET;
      cfg_window = WINDOW_RESET;
      g_start_x  = '0;
      g_start_y  = '0;
      g_prev_y   = '0;
      g_tap_x    = '0;
      g_tap_y    = '0;
      g_tap_time = '0;
      g_down     = 1'b0;
      g_drag     = 1'b0;
      g_tap_ok   = 1'b0;
   endfunction

   // next-state and result words for one touch word
   function automatic void classify_touch(input cmd_type cmd, input logic [15:0] x,
                                          input logic [15:0] y, input logic [31:0] now);
      int           ax, ay, wheel_px, dx, dy;
      logic [31:0]  elapsed;
      bit           was_tap, was_drag, dbl;
      step_res = {};
      case (cmd)
         CMD_DOWN: begin
            g_start_x = x;
            g_start_y = y;
            g_prev_y  = y;
            g_drag    = 1'b0;
            g_down    = 1'b1;
            step_res.insert(step_res.size(), mk_result(KIND_HOVER, x, y, 0, 0, 0, 1'b1));
         end
         CMD_MOVE: begin
            if (g_down) begin
               if (!g_drag) begin
                  ax = abs_diff(x, g_start_x);
                  ay = abs_diff(y, g_start_y);
                  if (longint'(ax) * ax + longint'(ay) * ay > longint'(cfg_slop) * cfg_slop)
                     g_drag = 1'b1;
               end
               if (g_drag) begin
                  wheel_px = px_half_away(int'(y) - int'(g_prev_y));
                  g_prev_y = y;
                  if (wheel_px != 0)
                     step_res.insert(step_res.size(),
                                     mk_result(KIND_WHEEL, x, y, wheel_px, 0, 0, 1'b1));
               end
            end
         end
         default: begin
            was_tap  = g_down && !g_drag && (cmd != CMD_CANCEL);
            was_drag = g_down && g_drag && (cmd != CMD_CANCEL);
            dx = px_toward_zero(int'(x) - int'(g_start_x));
            dy = px_toward_zero(int'(y) - int'(g_start_y));
            g_down = 1'b0;
            g_drag = 1'b0;
            if (was_drag) begin
               step_res.insert(step_res.size(),
                               mk_result(KIND_DRAG_END, x, y, 0, dx, dy, 1'b1));
            end else if (was_tap) begin
               elapsed = now - g_tap_time;
               dbl = g_tap_ok && (elapsed < {16'd0, cfg_window}) &&
                     (abs_diff(x, g_tap_x) < int'(cfg_slop)) &&
                     (abs_diff(y, g_tap_y) < int'(cfg_slop));
               g_tap_time = now;
               g_tap_x    = x;
               g_tap_y    = y;
               g_tap_ok   = !dbl;
               step_res.insert(step_res.size(), mk_result(KIND_HOVER, x, y, 0, 0, 0, 1'b0));
               step_res.insert(step_res.size(), mk_result(dbl ? KIND_DOUBLE : KIND_CLICK,
                                                          x, y, 0, 0, 0, 1'b1));
            end
         end
      endcase
   endfunction

   function automatic void take_word(input touch_row_type w);
      classify_touch(w.cmd, w.x, w.y, w.t);
      if (w.typed) begin
         step_res = {};
         if (w.n >= 1)
            step_res.insert(step_res.size(), mk_result(w.k0, w.x, w.y, 0, 0, 0, w.n == 1));
         if (w.n == 2)
            step_res.insert(step_res.size(), mk_result(w.k1, w.x, w.y, 0, 0, 0, 1'b1));
      end
      foreach (step_res[i]) pending_gestures.insert(pending_gestures.size(), step_res[i]);
      words_taken++;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                  input logic [15:0] exp_v);
      $display("%0t mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
               $realtime, results_seen, what, got_v, exp_v);
      errors++;
   endtask

   task automatic check_result();
      result_type got, want;
      got.kind        = kind_type'(rsp_tuser);
      got.px_x        = rsp_tdata[11:0];
      got.px_y        = rsp_tdata[23:12];
      got.wheel_step  = rsp_tdata[37:24];
      got.drag_dx     = rsp_tdata[51:38];
      got.drag_dy     = rsp_tdata[65:52];
      got.last        = rsp_tlast;
      results_seen++;
      if (pending_gestures.size() == 0) begin
         report_mismatch("unexpected word, kind", 16'(got.kind), '0);
         return;
      end
      want = pending_gestures.pop_front();
      if (got.kind != want.kind)
         report_mismatch("kind", 16'(got.kind), 16'(want.kind));
      if (got.px_x != want.px_x)
         report_mismatch("px_x", 16'(got.px_x), 16'(want.px_x));
      if (got.px_y != want.px_y)
         report_mismatch("px_y", 16'(got.px_y), 16'(want.px_y));
      if (got.wheel_step != want.wheel_step)
         report_mismatch("wheel_step", 16'(got.wheel_step), 16'(want.wheel_step));
      if (got.drag_dx != want.drag_dx)
         report_mismatch("drag_dx", 16'(got.drag_dx), 16'(want.drag_dx));
      if (got.drag_dy != want.drag_dy)
         report_mismatch("drag_dy", 16'(got.drag_dy), 16'(want.drag_dy));
      if (got.last != want.last)
         report_mismatch("last", 16'(got.last), 16'(want.last));
      if (want.kind <= KIND_DOUBLE) kind_seen[want.kind]++;
   endtask

   // touch word sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) take_word(cur_word);
         if (!(req_tvalid && !req_tready)) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_gap) begin
               cur_word = stim_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_word.t, cur_word.y, cur_word.x};
               req_tuser  <= cur_word.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(99) >= recv_gap);
      end
   end

   // watchdog: any accepted word on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles, %0d results still expected",
                  stall_cycles, pending_gestures.size());
         $display("tb_touch_tap_drag_classifier NOT OK");
         $finish;
      end
   end

   function automatic logic [15:0] near(input int base, input int span);
      int v;
      v = base + int'($urandom_range(2 * span, 0)) - span;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   task automatic push_word(input cmd_type c, input logic [15:0] x, input logic [15:0] y,
                            input logic [31:0] t);
      touch_row_type r;
      r.cmd   = c;
      r.x     = x;
      r.y     = y;
      r.t     = t;
      r.typed = 1'b0;
      r.n     = 0;
      r.k0    = KIND_HOVER;
      r.k1    = KIND_HOVER;
      stim_q.insert(stim_q.size(), r);
      words_issued++;
   endtask

   // mostly whole strokes with random content, the rest noise
   task automatic gen_strokes(input int budget);
      int           made, moves, span;
      logic [15:0]  cx, cy;
      made = 0;
      while (made < budget) begin
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(99) < 40) begin
               cx = near(tap_hint_x, cfg_slop + 16);
               cy = near(tap_hint_y, cfg_slop + 16);
            end else begin
               cx = 16'($urandom);
               cy = 16'($urandom);
            end
            push_word(CMD_DOWN, cx, cy, now_ms);
            moves = $urandom_range(4);
            repeat (moves) begin
               now_ms += $urandom_range(30);
               span = $urandom_range(1) ? cfg_slop / 2 + 8
                                        : 2 * cfg_slop + 256 + $urandom_range(4000);
               cx = near(cx, span);
               cy = near(cy, span);
               push_word(CMD_MOVE, cx, cy, now_ms);
            end
            now_ms += $urandom_range(60);
            if ($urandom_range(99) < 88) begin
               cx = near(cx, 24);
               cy = near(cy, 24);
               push_word(CMD_UP, cx, cy, now_ms);
               tap_hint_x = cx;
               tap_hint_y = cy;
            end else begin
               push_word(CMD_CANCEL, 16'($urandom), 16'($urandom), now_ms);
            end
            made += moves + 2;
            now_ms += $urandom_range(2 * cfg_window + 4);
            if ($urandom_range(99) < 3) now_ms += $urandom;
         end else begin
            push_word(cmd_type'(2'($urandom)), 16'($urandom), 16'($urandom), $urandom);
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (words_taken != words_issued || pending_gestures.size() != 0)
         @(posedge clock);
      // zero-result words may still be in flight
      repeat (6) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] slop_w, input logic [15:0] window_w);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_SLOP;
      csr_data  <= slop_w;
      do @(posedge clock); while (!csr_ready);
      cfg_slop = slop_w[SLOP_BITS-1:0];
      csr_index <= REG_WINDOW;
      csr_data  <= window_w;
      do @(posedge clock); while (!csr_ready);
      cfg_window = window_w;
      csr_valid <= 1'b0;
      cfg_writes += 2;
   endtask

   initial begin
      logic [15:0] slop_w, window_w;
      reset_gestures();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         stim_q.insert(stim_q.size(), dir_tab[i]);
         words_issued++;
      end
      wait_drained();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 2) begin
            send_gap = 58;
            recv_gap = 13;
         end else if (seg == 4) begin
            send_gap = 0;
            recv_gap = 0;
         end
         case (seg)
            0: begin slop_w = 16'h0000; window_w = 16'h0000; end
            1: begin slop_w = 16'hFFFF; window_w = 16'hFFFF; end
            2: begin slop_w = 16'($urandom_range(1023)); window_w = 16'($urandom_range(2000)); end
            3: begin slop_w = 16'd16; window_w = 16'hFFFF; end
            4: begin slop_w = 16'($urandom); window_w = 16'($urandom); end
            default: begin slop_w = 16'hF180; window_w = 16'd400; end  // upper bits ignored
         endcase
         write_regs(slop_w, window_w);
         // short gap before the next stroke batch
         repeat (3) @(posedge clock);
         gen_strokes(80);
         wait_drained();
      end
      repeat (10) @(posedge clock);

      $display("covered %0d touch words under %0d register writes, %0d result words checked",
               words_taken, cfg_writes, results_seen);
      $display("hover %0d, wheel %0d, drag end %0d, click %0d, double click %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (errors == 0)
         $display("tb_touch_tap_drag_classifier OK");
      else
         $display("tb_touch_tap_drag_classifier NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ttdc_pkg.sv
hw/rtl/ttdc_eval.sv
hw/rtl/ttdc_out_fifo.sv
hw/rtl/touch_tap_drag_classifier.sv
hw/rtl/ttdc_checker.sv
verif/tb_touch_tap_drag_classifier.sv
